// File: rtl/core/assert_macros.svh
// assertion macros used by the checker file
// expects signals named clk and rst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/ile_pkg.sv
// types, constants and codes for the indexed list engine
// used by the top level and the checker; depends on nothing
package ile_pkg;

  localparam int CAPACITY   = 64;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  // operation codes carried in the mode field
  typedef enum logic [3:0] {
    M_PUSH_BACK  = 4'd0,
    M_PUSH_FRONT = 4'd1,
    M_INSERT     = 4'd2,
    M_POP_BACK   = 4'd3,
    M_POP_FRONT  = 4'd4,
    M_REMOVE     = 4'd5,
    M_REPLACE    = 4'd6,
    M_SWAP       = 4'd7,
    M_READ       = 4'd8
  } mode_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_UP,
    S_PUT,
    S_DN,
    S_RDW,
    S_SWA,
    S_SWB,
    S_SWC,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [3:0]         mode;
    logic [6:0]         index;
    logic [5:0]         second_index;
    logic signed [31:0] value;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic [1:0]         status;
    logic [6:0]         count;
  } out_word_t;

endpackage

// File: rtl/core/ile_ram.sv
// entry memory: one write port, one read port with registered read data
// generic; no package dependency
module ile_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // read port, data holds while not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/core/indexed_list_engine_core.sv
// top level of the indexed list engine: command sequencer and output register
// depends on ile_pkg and ile_ram
//
// Bounded ordered list of up to 64 words kept in one entry memory with one
// read and one write port. One command word is worked on at a time, and each
// gives one result word holding the read data, a status code and the count
// after the command. Insert and push-front move entries up one place to open
// a slot; remove and pop-front move entries down one place to close one. The
// moves stream through the memory read port one entry a cycle. The result
// word becomes valid in the same cycle as the sequencer returns to idle. A
// result that waits in the output register holds the sequencer in its last
// step only when a second result is ready behind it. A new command is taken
// whenever the sequencer is idle, even while the previous result still waits
// in the output register. Entries need no clearing after reset.
module indexed_list_engine_core
  import ile_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] ptr_r, ptr_nxt;
  logic [CNT_W-1:0] pos_r, pos_nxt;
  logic             pend_r, pend_nxt;
  logic [IDX_W-1:0] pend_addr_r, pend_addr_nxt;
  in_word_t         cmd_r, cmd_nxt;
  status_t          status_r, status_nxt;
  logic [31:0]      rv_r, rv_nxt;
  logic [DATA_WIDTH-1:0] tmp_r, tmp_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_word_t        out_r, out_nxt;

  logic                  wr_en, rd_en;
  logic [IDX_W-1:0]      wr_addr, rd_addr;
  logic [DATA_WIDTH-1:0] wr_data, rd_data;

  logic             full;
  logic [CNT_W-1:0] ptr_inc, ptr_dec;

  assign full    = (count_r == CNT_W'(CAPACITY));
  assign ptr_inc = ptr_r + CNT_W'(1);
  assign ptr_dec = ptr_r - CNT_W'(1);

  ile_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (DATA_WIDTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    ptr_r       <= ptr_nxt;
    pos_r       <= pos_nxt;
    pend_addr_r <= pend_addr_nxt;
    cmd_r       <= cmd_nxt;
    status_r    <= status_nxt;
    rv_r        <= rv_nxt;
    tmp_r       <= tmp_nxt;
    out_r       <= out_nxt;
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ptr_nxt       = ptr_r;
    pos_nxt       = pos_r;
    pend_nxt      = pend_r;
    pend_addr_nxt = pend_addr_r;
    cmd_nxt       = cmd_r;
    status_nxt    = status_r;
    rv_nxt        = rv_r;
    tmp_nxt       = tmp_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = '0;
    rd_en         = 1'b0;
    rd_addr       = '0;
    in_ready      = (state_r == S_IDLE);

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt    = in_data;
          status_nxt = ST_OK;
          rv_nxt     = '0;
          pend_nxt   = 1'b0;
          state_nxt  = S_RESP;
          unique case (mode_t'(in_data.mode))
            M_PUSH_BACK: begin
              if (full) begin
                status_nxt = ST_FULL;
              end else begin
                ptr_nxt   = count_r;
                pos_nxt   = count_r;
                state_nxt = S_UP;
              end
            end
            M_PUSH_FRONT: begin
              if (full) begin
                status_nxt = ST_FULL;
              end else begin
                ptr_nxt   = count_r;
                pos_nxt   = '0;
                state_nxt = S_UP;
              end
            end
            M_INSERT: begin
              if (in_data.index > count_r) begin
                status_nxt = ST_RANGE;
              end else if (full) begin
                status_nxt = ST_FULL;
              end else begin
                ptr_nxt   = count_r;
                pos_nxt   = in_data.index;
                state_nxt = S_UP;
              end
            end
            M_POP_BACK: begin
              if (count_r == '0) begin
                status_nxt = ST_EMPTY;
              end else begin
                count_nxt = count_r - CNT_W'(1);
              end
            end
            M_POP_FRONT: begin
              if (count_r == '0) begin
                status_nxt = ST_EMPTY;
              end else begin
                ptr_nxt   = '0;
                state_nxt = S_DN;
              end
            end
            M_REMOVE: begin
              if (in_data.index >= count_r) begin
                status_nxt = ST_RANGE;
              end else begin
                ptr_nxt   = in_data.index;
                state_nxt = S_DN;
              end
            end
            M_REPLACE: begin
              if (in_data.index >= count_r) begin
                status_nxt = ST_RANGE;
              end else begin
                wr_en   = 1'b1;
                wr_addr = in_data.index[IDX_W-1:0];
                wr_data = DATA_WIDTH'(in_data.value);
              end
            end
            M_SWAP: begin
              if (in_data.index >= count_r ||
                  {1'b0, in_data.second_index} >= count_r) begin
                status_nxt = ST_RANGE;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = in_data.index[IDX_W-1:0];
                state_nxt = S_SWA;
              end
            end
            M_READ: begin
              if (in_data.index >= count_r) begin
                status_nxt = ST_RANGE;
                rv_nxt     = '1;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = in_data.index[IDX_W-1:0];
                state_nxt = S_RDW;
              end
            end
            default: begin
              status_nxt = ST_OK;
            end
          endcase
        end
      end

      // move entries up one place, reading ahead of the write
      S_UP: begin
        if (pend_r) begin
          wr_en   = 1'b1;
          wr_addr = pend_addr_r;
          wr_data = rd_data;
        end
        if (ptr_r > pos_r) begin
          rd_en         = 1'b1;
          rd_addr       = ptr_dec[IDX_W-1:0];
          pend_nxt      = 1'b1;
          pend_addr_nxt = ptr_r[IDX_W-1:0];
          ptr_nxt       = ptr_dec;
        end else begin
          pend_nxt  = 1'b0;
          state_nxt = S_PUT;
        end
      end

      // store the new word in the opened slot
      S_PUT: begin
        wr_en     = 1'b1;
        wr_addr   = pos_r[IDX_W-1:0];
        wr_data   = DATA_WIDTH'(cmd_r.value);
        count_nxt = count_r + CNT_W'(1);
        state_nxt = S_RESP;
      end

      // move entries down one place over the closed slot
      S_DN: begin
        if (pend_r) begin
          wr_en   = 1'b1;
          wr_addr = pend_addr_r;
          wr_data = rd_data;
        end
        if (ptr_inc < count_r) begin
          rd_en         = 1'b1;
          rd_addr       = ptr_inc[IDX_W-1:0];
          pend_nxt      = 1'b1;
          pend_addr_nxt = ptr_r[IDX_W-1:0];
          ptr_nxt       = ptr_inc;
        end else begin
          pend_nxt  = 1'b0;
          count_nxt = count_r - CNT_W'(1);
          state_nxt = S_RESP;
        end
      end

      // read data arrives
      S_RDW: begin
        rv_nxt    = 32'(rd_data);
        state_nxt = S_RESP;
      end

      // swap: hold first word, fetch second
      S_SWA: begin
        tmp_nxt   = rd_data;
        rd_en     = 1'b1;
        rd_addr   = cmd_r.second_index[IDX_W-1:0];
        state_nxt = S_SWB;
      end

      S_SWB: begin
        wr_en     = 1'b1;
        wr_addr   = cmd_r.index[IDX_W-1:0];
        wr_data   = rd_data;
        state_nxt = S_SWC;
      end

      S_SWC: begin
        wr_en     = 1'b1;
        wr_addr   = cmd_r.second_index[IDX_W-1:0];
        wr_data   = tmp_r;
        state_nxt = S_RESP;
      end

      // load the output register once it is free
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_nxt.read_value = rv_r;
          out_nxt.status     = status_r;
          out_nxt.count      = count_r;
          out_valid_nxt      = 1'b1;
          state_nxt          = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: rtl/core/ile_chk.sv
// port-level checker for the indexed list engine, bound to the top level
// depends on ile_pkg and assert_macros.svh
`include "assert_macros.svh"

module ile_chk
  import ile_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_word_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_data
);

  // a result word waits until taken
  `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result word dropped")

  // count never passes the capacity
  `ASSERT_IMPL(a_cnt_max, out_valid, out_data.count <= 7'(CAPACITY), "count beyond capacity")

  // a full status only when the list is full
  `ASSERT_IMPL(a_full, out_valid && out_data.status == ST_FULL, out_data.count == 7'(CAPACITY), "full status with room left")

  // an empty status only on an empty list, with no read data
  `ASSERT_IMPL(a_empty, out_valid && out_data.status == ST_EMPTY, out_data.count == '0 && out_data.read_value == '0, "bad empty result")

endmodule

bind indexed_list_engine_core ile_chk u_ile_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
